@@ hw/rtl/lprt_pkg.sv @@
// lprt_pkg: shared constants, types and helpers of the route table
// no dependencies; imported by every module of the block
`default_nettype none

package lprt_pkg;

    localparam int ROUTE_CAPACITY = 16;
    localparam int IDX_W          = (ROUTE_CAPACITY > 1) ? $clog2(ROUTE_CAPACITY) : 1;
    localparam int CNT_W          = $clog2(ROUTE_CAPACITY + 1);
    localparam int ADDR_W         = 32;
    localparam int PLEN_W         = 6;
    localparam int IFACE_W        = 32;
    localparam int METRIC_W       = 16;
    localparam int CMD_W          = 2;
    localparam int MAX_PREFIX     = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_LOOKUP = 2'd2,
        CMD_NONE   = 2'd3
    } lprt_cmd_code_t;

    typedef struct packed {
        logic [ADDR_W-1:0]   network;
        logic [PLEN_W-1:0]   prefix;
        logic [ADDR_W-1:0]   gateway;
        logic [IFACE_W-1:0]  iface;
        logic [METRIC_W-1:0] metric;
    } lprt_entry_t;

    // controller to datapath
    typedef struct packed {
        logic start;
        logic scan;
        logic commit;
        logic out_load;
    } lprt_ctl_t;

    // datapath to controller
    typedef struct packed {
        logic scan_done;
    } lprt_sts_t;

    // top p bits set, zero for p = 0, all ones above 32
    function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PLEN_W-1:0] p);
        logic [ADDR_W-1:0] m;
        if (p == '0) begin
            m = '0;
        end else if (p > PLEN_W'(MAX_PREFIX)) begin
            m = '1;
        end else begin
            m = ~({ADDR_W{1'b1}} >> p);
        end
        return m;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/lprt_ctrl.sv @@
// lprt_ctrl: command sequencer of the route table
// depends on lprt_pkg; drives the datapath through lprt_ctl_t
`default_nettype none

module lprt_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  wire logic              m_ready,
    input  wire lprt_pkg::lprt_sts_t sts,
    output lprt_pkg::lprt_ctl_t    ctl
);
    import lprt_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   out_full_reg, out_full_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = out_full_reg;

    always_comb begin
        ctl           = '0;
        state_next    = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    ctl.start  = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                ctl.scan = 1'b1;
                if (sts.scan_done) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                ctl.commit = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                // hand off once the output register is free or draining
                if (!out_full_reg || m_ready) begin
                    ctl.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        out_full_next = ctl.out_load | (out_full_reg & ~m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            out_full_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            out_full_reg <= out_full_next;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/lprt_datapath.sv @@
// lprt_datapath: route memory, valid bits, scan compare and result register
// depends on lprt_pkg; sequenced by lprt_ctrl
`default_nettype none

module lprt_datapath (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire lprt_pkg::lprt_ctl_t             ctl,
    output lprt_pkg::lprt_sts_t                  sts,
    input  wire logic [lprt_pkg::CMD_W-1:0]      s_cmd,
    input  wire logic [lprt_pkg::ADDR_W-1:0]     s_address,
    input  wire logic [lprt_pkg::PLEN_W-1:0]     s_prefix_len,
    input  wire logic [lprt_pkg::ADDR_W-1:0]     s_next_hop,
    input  wire logic [lprt_pkg::IFACE_W-1:0]    s_iface,
    input  wire logic [lprt_pkg::METRIC_W-1:0]   s_cost,
    output logic                                 m_success,
    output logic [lprt_pkg::ADDR_W-1:0]          m_route_network,
    output logic [lprt_pkg::PLEN_W-1:0]          m_route_prefix,
    output logic [lprt_pkg::ADDR_W-1:0]          m_route_gateway,
    output logic [lprt_pkg::IFACE_W-1:0]         m_route_iface,
    output logic [lprt_pkg::METRIC_W-1:0]        m_route_metric
);
    import lprt_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ROUTE_CAPACITY - 1);

    lprt_entry_t mem [ROUTE_CAPACITY];
    logic [ROUTE_CAPACITY-1:0] valid_reg;

    // latched command
    lprt_cmd_code_t      cmd_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [ADDR_W-1:0]   net_reg;
    logic                bad_reg;
    lprt_entry_t         wr_entry_reg;

    // scan pipeline
    logic [CNT_W-1:0]    rd_cnt_reg;
    logic [IDX_W-1:0]    rd_addr;
    logic                rd_issue;
    lprt_entry_t         rd_data_reg;
    logic [IDX_W-1:0]    cmp_idx_reg;
    logic                cmp_vld_reg;

    // scan findings
    logic                match_found_reg;
    logic [IDX_W-1:0]    match_idx_reg;
    logic                free_found_reg;
    logic [IDX_W-1:0]    free_idx_reg;
    logic                best_found_reg;
    lprt_entry_t         best_reg;

    logic                cmp_v;
    logic                same;
    logic                hit;
    logic                better;
    logic                add_ok;
    logic [IDX_W-1:0]    add_idx;
    logic                res_success;
    lprt_entry_t         res_entry;

    assign rd_issue = ctl.scan && (rd_cnt_reg < CNT_W'(ROUTE_CAPACITY));
    assign rd_addr  = rd_cnt_reg[IDX_W-1:0];
    assign sts.scan_done = cmp_vld_reg && (cmp_idx_reg == LAST_IDX);

    always_comb begin
        cmp_v  = valid_reg[cmp_idx_reg];
        same   = cmp_v && (rd_data_reg.network == net_reg)
                 && (rd_data_reg.prefix == wr_entry_reg.prefix)
                 && (rd_data_reg.iface == wr_entry_reg.iface);
        hit    = cmp_v && ((addr_reg & prefix_mask(rd_data_reg.prefix))
                           == rd_data_reg.network);
        better = !best_found_reg
                 || (rd_data_reg.prefix > best_reg.prefix)
                 || ((rd_data_reg.prefix == best_reg.prefix)
                     && (rd_data_reg.metric < best_reg.metric));

        // an existing route wins over the first free slot
        add_ok  = !bad_reg && (match_found_reg || free_found_reg);
        add_idx = match_found_reg ? match_idx_reg : free_idx_reg;

        res_success = 1'b0;
        res_entry   = '0;
        unique case (cmd_reg)
            CMD_ADD:    res_success = add_ok;
            CMD_REMOVE: res_success = !bad_reg && match_found_reg;
            CMD_LOOKUP: begin
                res_success = best_found_reg;
                if (best_found_reg) begin
                    res_entry = best_reg;
                end
            end
            default:    res_success = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            cmd_reg              <= lprt_cmd_code_t'(s_cmd);
            addr_reg             <= s_address;
            net_reg              <= s_address & prefix_mask(s_prefix_len);
            bad_reg              <= (s_prefix_len > PLEN_W'(MAX_PREFIX)) || (s_iface == '0);
            wr_entry_reg.network <= s_address & prefix_mask(s_prefix_len);
            wr_entry_reg.prefix  <= s_prefix_len;
            wr_entry_reg.gateway <= s_next_hop;
            wr_entry_reg.iface   <= s_iface;
            wr_entry_reg.metric  <= s_cost;
        end
        if (rd_issue) begin
            rd_data_reg <= mem[rd_addr];
        end
        cmp_idx_reg <= rd_addr;
        if (cmp_vld_reg) begin
            if (same && !match_found_reg) begin
                match_idx_reg <= cmp_idx_reg;
            end
            if (!cmp_v && !free_found_reg) begin
                free_idx_reg <= cmp_idx_reg;
            end
            if (hit && better) begin
                best_reg <= rd_data_reg;
            end
        end
        if (ctl.commit && (cmd_reg == CMD_ADD) && add_ok) begin
            mem[add_idx] <= wr_entry_reg;
        end
        if (ctl.out_load) begin
            m_success       <= res_success;
            m_route_network <= res_entry.network;
            m_route_prefix  <= res_entry.prefix;
            m_route_gateway <= res_entry.gateway;
            m_route_iface   <= res_entry.iface;
            m_route_metric  <= res_entry.metric;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg       <= '0;
            rd_cnt_reg      <= '0;
            cmp_vld_reg     <= 1'b0;
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            best_found_reg  <= 1'b0;
        end else begin
            cmp_vld_reg <= rd_issue;
            if (ctl.start) begin
                rd_cnt_reg      <= '0;
                match_found_reg <= 1'b0;
                free_found_reg  <= 1'b0;
                best_found_reg  <= 1'b0;
            end else begin
                if (rd_issue) begin
                    rd_cnt_reg <= rd_cnt_reg + CNT_W'(1);
                end
                if (cmp_vld_reg) begin
                    if (same) begin
                        match_found_reg <= 1'b1;
                    end
                    if (!cmp_v) begin
                        free_found_reg <= 1'b1;
                    end
                    if (hit) begin
                        best_found_reg <= 1'b1;
                    end
                end
            end
            if (ctl.commit) begin
                if ((cmd_reg == CMD_ADD) && add_ok) begin
                    valid_reg[add_idx] <= 1'b1;
                end else if ((cmd_reg == CMD_REMOVE) && !bad_reg && match_found_reg) begin
                    valid_reg[match_idx_reg] <= 1'b0;
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/ipv4_longest_prefix_route_table_top.sv @@
// ipv4_longest_prefix_route_table_top: top level of the ipv4 route table
// depends on lprt_pkg, lprt_ctrl and lprt_datapath
//
//   channel | direction | handshake          | payload
//   s_      | in        | s_valid / s_ready  | cmd, address, prefix_len, next_hop, iface, cost
//   m_      | out       | m_valid / m_ready  | success, route_network .. route_metric
//
// one command at a time; each passes through the accept step, the scan
// (one read per route entry from the single-port route memory, the compare
// running in the cycle after the registered read), the commit step and the
// hand-off into the result register
// a new command is taken while the previous result beat still waits on m_ready;
// the hand-off waits only if that older beat is still not taken
// reset (synchronous, active low) clears all valid bits at once: no clearing pass
`default_nettype none

module ipv4_longest_prefix_route_table_top (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [lprt_pkg::CMD_W-1:0]      s_cmd,
    input  wire logic [lprt_pkg::ADDR_W-1:0]     s_address,
    input  wire logic [lprt_pkg::PLEN_W-1:0]     s_prefix_len,
    input  wire logic [lprt_pkg::ADDR_W-1:0]     s_next_hop,
    input  wire logic [lprt_pkg::IFACE_W-1:0]    s_iface,
    input  wire logic [lprt_pkg::METRIC_W-1:0]   s_cost,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic                                 m_success,
    output logic [lprt_pkg::ADDR_W-1:0]          m_route_network,
    output logic [lprt_pkg::PLEN_W-1:0]          m_route_prefix,
    output logic [lprt_pkg::ADDR_W-1:0]          m_route_gateway,
    output logic [lprt_pkg::IFACE_W-1:0]         m_route_iface,
    output logic [lprt_pkg::METRIC_W-1:0]        m_route_metric
);
    import lprt_pkg::*;

    // command and status between sequencer and datapath
    lprt_ctl_t ctl;
    lprt_sts_t sts;

    // sequencer: owns s_ready and the result-valid flag
    lprt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .ctl     (ctl)
    );

    // datapath: route memory, scan compare, result payload register
    lprt_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .ctl             (ctl),
        .sts             (sts),
        .s_cmd           (s_cmd),
        .s_address       (s_address),
        .s_prefix_len    (s_prefix_len),
        .s_next_hop      (s_next_hop),
        .s_iface         (s_iface),
        .s_cost          (s_cost),
        .m_success       (m_success),
        .m_route_network (m_route_network),
        .m_route_prefix  (m_route_prefix),
        .m_route_gateway (m_route_gateway),
        .m_route_iface   (m_route_iface),
        .m_route_metric  (m_route_metric)
    );

`ifndef SYNTHESIS
    // an accepted command holds the block busy for its scan
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken again right after an accepted beat");

    // the end of the scan always leads into the commit step
    a_commit_after_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        sts.scan_done |=> ctl.commit)
        else $error("scan finished without commit");

    // a result beat is loaded only from a finished command
    a_load_after_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.out_load |-> !ctl.scan && !ctl.start)
        else $error("result loaded while a scan is active");

    // a failed command carries an all-zero route
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_success) |-> (m_route_prefix == '0) && (m_route_metric == '0)
            && (m_route_network == '0) && (m_route_iface == '0))
        else $error("route fields set on a failed result");
`endif

endmodule

`default_nettype wire

@@ tb/lprt_route_checker.sv @@
`timescale 1ns / 1ps
// lprt_route_checker: scoreboard of the ipv4 route table, keeps its own copy of the
// route entries, predicts every result beat and compares it field by field
// depends on lprt_pkg for widths, command codes and the route entry layout
module lprt_route_checker
    import lprt_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    input  wire logic                  s_ready,
    input  wire logic [CMD_W-1:0]      s_cmd,
    input  wire logic [ADDR_W-1:0]     s_address,
    input  wire logic [PLEN_W-1:0]     s_prefix_len,
    input  wire logic [ADDR_W-1:0]     s_next_hop,
    input  wire logic [IFACE_W-1:0]    s_iface,
    input  wire logic [METRIC_W-1:0]   s_cost,
    input  wire logic                  m_valid,
    input  wire logic                  m_ready,
    input  wire logic                  m_success,
    input  wire logic [ADDR_W-1:0]     m_route_network,
    input  wire logic [PLEN_W-1:0]     m_route_prefix,
    input  wire logic [ADDR_W-1:0]     m_route_gateway,
    input  wire logic [IFACE_W-1:0]    m_route_iface,
    input  wire logic [METRIC_W-1:0]   m_route_metric,
    output logic [31:0]                fail_count,
    output logic [31:0]                lookup_hits,
    output logic [31:0]                full_rejects
);

    typedef struct packed {
        logic                ok;
        logic [ADDR_W-1:0]   network;
        logic [PLEN_W-1:0]   prefix;
        logic [ADDR_W-1:0]   gateway;
        logic [IFACE_W-1:0]  iface;
        logic [METRIC_W-1:0] metric;
    } route_answer_t;

    logic          tbl_valid [ROUTE_CAPACITY];
    lprt_entry_t   tbl_entry [ROUTE_CAPACITY];
    route_answer_t pending_answers [$];
    route_answer_t want;
    route_answer_t fresh;
    logic [31:0]   mismatch_cnt = '0;
    logic [31:0]   waiting      = '0;

    assign fail_count = mismatch_cnt + waiting;

    // top p bits set; p = 0 gives no bits
    function automatic logic [ADDR_W-1:0] net_mask(input logic [PLEN_W-1:0] p);
        logic [63:0] wide;
        wide = 64'hFFFF_FFFF_0000_0000 >> p;
        return wide[31:0];
    endfunction

    task automatic apply_route_cmd(
        input  lprt_cmd_code_t       cmd,
        input  logic [ADDR_W-1:0]    addr,
        input  logic [PLEN_W-1:0]    plen,
        input  logic [ADDR_W-1:0]    hop,
        input  logic [IFACE_W-1:0]   ifc,
        input  logic [METRIC_W-1:0]  cst,
        output route_answer_t        ans
    );
        logic [ADDR_W-1:0] net;
        int                match;
        int                slot;
        int                k;
        ans   = '0;
        match = -1;
        slot  = -1;
        net   = addr & net_mask(plen);
        case (cmd)
            CMD_ADD, CMD_REMOVE: begin
                if (plen <= PLEN_W'(MAX_PREFIX) && ifc != '0) begin
                    for (k = 0; k < ROUTE_CAPACITY; k++) begin
                        if (match < 0 && tbl_valid[k] && tbl_entry[k].network == net &&
                            tbl_entry[k].prefix == plen && tbl_entry[k].iface == ifc)
                            match = k;
                        if (slot < 0 && !tbl_valid[k])
                            slot = k;
                    end
                    if (cmd == CMD_REMOVE) begin
                        if (match >= 0) begin
                            tbl_valid[match] = 1'b0;
                            ans.ok = 1'b1;
                        end
                    end else begin
                        // an identical route is refreshed in place before a free slot is used
                        if (match >= 0)
                            slot = match;
                        if (slot >= 0) begin
                            tbl_entry[slot].network = net;
                            tbl_entry[slot].prefix  = plen;
                            tbl_entry[slot].gateway = hop;
                            tbl_entry[slot].iface   = ifc;
                            tbl_entry[slot].metric  = cst;
                            tbl_valid[slot] = 1'b1;
                            ans.ok = 1'b1;
                        end else begin
                            full_rejects++;
                        end
                    end
                end
            end
            CMD_LOOKUP: begin
                // longest prefix, then lower metric, then lower index
                for (k = 0; k < ROUTE_CAPACITY; k++) begin
                    if (tbl_valid[k] &&
                        (addr & net_mask(tbl_entry[k].prefix)) == tbl_entry[k].network) begin
                        if (match < 0 || tbl_entry[k].prefix > tbl_entry[match].prefix ||
                            (tbl_entry[k].prefix == tbl_entry[match].prefix &&
                             tbl_entry[k].metric < tbl_entry[match].metric))
                            match = k;
                    end
                end
                if (match >= 0) begin
                    ans.ok      = 1'b1;
                    ans.network = tbl_entry[match].network;
                    ans.prefix  = tbl_entry[match].prefix;
                    ans.gateway = tbl_entry[match].gateway;
                    ans.iface   = tbl_entry[match].iface;
                    ans.metric  = tbl_entry[match].metric;
                    lookup_hits++;
                end
            end
            default: begin
            end
        endcase
    endtask

    task automatic check_field(input string fname, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (exp_val !== act_val) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, exp_val, act_val);
            mismatch_cnt++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < ROUTE_CAPACITY; k++)
                tbl_valid[k] = 1'b0;
            pending_answers.delete();
            mismatch_cnt = '0;
            waiting      = '0;
            lookup_hits  = '0;
            full_rejects = '0;
        end else begin
            // result side first, so a beat from an empty block is never matched
            // against a command taken in the same cycle
            if (m_valid && m_ready) begin
                if (pending_answers.size() == 0) begin
                    $display("%0t: result beat, expected none, actual success %b network %h",
                             $time, m_success, m_route_network);
                    mismatch_cnt++;
                end else begin
                    want = pending_answers.pop_front();
                    check_field("success", 32'(want.ok), 32'(m_success));
                    check_field("route_network", want.network, m_route_network);
                    check_field("route_prefix", 32'(want.prefix), 32'(m_route_prefix));
                    check_field("route_gateway", want.gateway, m_route_gateway);
                    check_field("route_iface", want.iface, m_route_iface);
                    check_field("route_metric", 32'(want.metric), 32'(m_route_metric));
                end
            end
            if (s_valid && s_ready) begin
                apply_route_cmd(lprt_cmd_code_t'(s_cmd), s_address, s_prefix_len,
                                s_next_hop, s_iface, s_cost, fresh);
                pending_answers.push_back(fresh);
            end
            waiting = pending_answers.size();
        end
    end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// tb_top: stimulus, handshake pacing and verdict for the ipv4 route table
// depends on lprt_pkg, ipv4_longest_prefix_route_table_top and lprt_route_checker
module tb_top;

    import lprt_pkg::*;

    // a long receiver hold-off and the no-beat limit, both in clock cycles
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    // random traffic draws routes from a small pool of keys built on a few base
    // addresses, so keys nest, collide, overwrite and fill the table
    localparam int BASES = 4;
    localparam int KEYS  = 24;

    logic                 aclk    = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [CMD_W-1:0]     s_cmd        = '0;
    logic [ADDR_W-1:0]    s_address    = '0;
    logic [PLEN_W-1:0]    s_prefix_len = '0;
    logic [ADDR_W-1:0]    s_next_hop   = '0;
    logic [IFACE_W-1:0]   s_iface      = '0;
    logic [METRIC_W-1:0]  s_cost       = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic                 m_success;
    logic [ADDR_W-1:0]    m_route_network;
    logic [PLEN_W-1:0]    m_route_prefix;
    logic [ADDR_W-1:0]    m_route_gateway;
    logic [IFACE_W-1:0]   m_route_iface;
    logic [METRIC_W-1:0]  m_route_metric;

    logic [31:0]          fail_count;
    logic [31:0]          lookup_hits;
    logic [31:0]          full_rejects;

    // pacing knobs: percent of cycles the sender idles and the receiver stalls
    int unsigned          send_idle_pct = 0;
    int unsigned          stall_pct     = 0;
    // bumping the token asks the receiver for one long hold-off
    int unsigned          hold_token = 0;
    int unsigned          hold_seen  = 0;
    int unsigned          hold_left  = 0;
    // beats counted at the ports, used for draining and the watchdog
    int unsigned          beats_in     = 0;
    int unsigned          beats_out    = 0;
    int unsigned          quiet_cycles = 0;
    int unsigned          cmd_count [4];

    logic [ADDR_W-1:0]    base_addr [BASES];
    logic [PLEN_W-1:0]    key_plen  [KEYS];
    logic [IFACE_W-1:0]   key_ifc   [KEYS];
    int unsigned          key_base  [KEYS];

    // 20 ns clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    ipv4_longest_prefix_route_table_top u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_address       (s_address),
        .s_prefix_len    (s_prefix_len),
        .s_next_hop      (s_next_hop),
        .s_iface         (s_iface),
        .s_cost          (s_cost),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_success       (m_success),
        .m_route_network (m_route_network),
        .m_route_prefix  (m_route_prefix),
        .m_route_gateway (m_route_gateway),
        .m_route_iface   (m_route_iface),
        .m_route_metric  (m_route_metric)
    );

    lprt_route_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_address       (s_address),
        .s_prefix_len    (s_prefix_len),
        .s_next_hop      (s_next_hop),
        .s_iface         (s_iface),
        .s_cost          (s_cost),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_success       (m_success),
        .m_route_network (m_route_network),
        .m_route_prefix  (m_route_prefix),
        .m_route_gateway (m_route_gateway),
        .m_route_iface   (m_route_iface),
        .m_route_metric  (m_route_metric),
        .fail_count      (fail_count),
        .lookup_hits     (lookup_hits),
        .full_rejects    (full_rejects)
    );

    // receiver: random stalls, or one long hold-off per token bump; while it holds
    // off the block keeps one result waiting, takes one more command and then
    // drops s_ready
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (hold_seen != hold_token) begin
            hold_seen <= hold_token;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // beat counters and watchdog; counters move by nonblocking update so the
    // stimulus process always sees the values from before the edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                beats_in <= beats_in + 1;
            if (m_valid && m_ready)
                beats_out <= beats_out + 1;
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no beat on either channel for %0d cycles", quiet_cycles);
                $display("DONE: errors detected");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // present one command beat, with random idle cycles ahead of it, and hold it
    // until the block takes it; returns at the accepting edge
    task automatic offer(input lprt_cmd_code_t c, input logic [ADDR_W-1:0] addr,
                         input logic [PLEN_W-1:0] plen, input logic [ADDR_W-1:0] hop,
                         input logic [IFACE_W-1:0] ifc, input logic [METRIC_W-1:0] cst);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_cmd        <= c;
        s_address    <= addr;
        s_prefix_len <= plen;
        s_next_hop   <= hop;
        s_iface      <= ifc;
        s_cost       <= cst;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        cmd_count[int'(c)]++;
    endtask

    // stop sending and wait until every command has its result beat back
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (beats_in != beats_out)
            @(posedge aclk);
    endtask

    // new key: prefixes cluster on /8, /16 and /24 so equal prefixes meet often,
    // interfaces are small ids half the time so keys share them
    task automatic refresh_key(input int unsigned i);
        key_base[i] = $urandom_range(BASES - 1);
        case ($urandom_range(3))
            0:       key_plen[i] = 6'd8;
            1:       key_plen[i] = 6'd16;
            2:       key_plen[i] = 6'd24;
            default: key_plen[i] = PLEN_W'($urandom_range(MAX_PREFIX));
        endcase
        key_ifc[i] = $urandom_range(1) ? IFACE_W'($urandom_range(3, 1)) : IFACE_W'($urandom);
        if (key_ifc[i] == '0)
            key_ifc[i] = 'd1;
    endtask

    // one random command: mostly well-formed traffic on the key pool, with a few
    // noise beats (any code, any prefix length, often a zero interface)
    task automatic random_command(input int unsigned add_pct, input int unsigned rm_pct);
        int unsigned          pick;
        int unsigned          i;
        lprt_cmd_code_t       c;
        logic [ADDR_W-1:0]    addr;
        logic [PLEN_W-1:0]    plen;
        logic [IFACE_W-1:0]   ifc;
        logic [METRIC_W-1:0]  cst;
        pick = $urandom_range(99);
        if ($urandom_range(19) == 0)
            refresh_key($urandom_range(KEYS - 1));
        i    = $urandom_range(KEYS - 1);
        plen = key_plen[i];
        ifc  = key_ifc[i];
        // host bits below the prefix are random: masked away by add and remove,
        // and still a hit for lookup
        addr = base_addr[key_base[i]] ^ ($urandom & (32'hFFFF_FFFF >> plen));
        // low metrics often, so metric ties fall back on the entry index
        cst  = $urandom_range(1) ? METRIC_W'($urandom_range(3)) : METRIC_W'($urandom);
        if (pick < 4) begin
            c    = lprt_cmd_code_t'($urandom_range(3));
            addr = $urandom;
            plen = PLEN_W'($urandom_range(63));
            ifc  = ($urandom_range(3) == 0) ? '0 : IFACE_W'($urandom);
            cst  = METRIC_W'($urandom);
        end else if (pick < 4 + add_pct) begin
            c = CMD_ADD;
        end else if (pick < 4 + add_pct + rm_pct) begin
            c = CMD_REMOVE;
            // now and then a wrong interface, so the remove misses
            if ($urandom_range(7) == 0)
                ifc = ifc ^ (32'd1 << $urandom_range(31));
        end else begin
            c = CMD_LOOKUP;
            if ($urandom_range(9) == 0)
                addr = $urandom;
        end
        offer(c, addr, plen, $urandom, ifc, cst);
    endtask

    task automatic run_phase(input int unsigned idle_pct, input int unsigned stall,
                             input int unsigned add_pct, input int unsigned rm_pct,
                             input int unsigned count);
        send_idle_pct = idle_pct;
        stall_pct    <= stall;
        repeat (count)
            random_command(add_pct, rm_pct);
    endtask

    initial begin
        for (int k = 0; k < 4; k++)
            cmd_count[k] = 0;
        for (int b = 0; b < BASES; b++)
            base_addr[b] = $urandom;
        for (int k = 0; k < KEYS; k++)
            refresh_key(k);

        // reset held low, then released at an edge
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // directed part, no idling
        // empty table: lookup misses, unknown code does nothing
        offer(CMD_LOOKUP, 32'h0000_0000, 6'd0, 32'h0, 32'h0, 16'h0);
        offer(CMD_NONE, 32'hFFFF_FFFF, 6'h3F, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        // rejected adds: prefix over 32, largest prefix code, zero interface
        offer(CMD_ADD, 32'h0A00_0000, 6'd33, 32'h1, 32'h1, 16'h1);
        offer(CMD_ADD, 32'h0A00_0000, 6'h3F, 32'h1, 32'h1, 16'h1);
        offer(CMD_ADD, 32'h0A00_0000, 6'd8, 32'h1, 32'h0, 16'h1);
        // default route from an all-ones address, all-ones fields
        offer(CMD_ADD, 32'hFFFF_FFFF, 6'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        // host route, zero gateway and metric
        offer(CMD_ADD, 32'hFFFF_FFFF, 6'd32, 32'h0, 32'h1, 16'h0);
        // two /8 routes with equal metric on different interfaces, one /16 inside
        offer(CMD_ADD, 32'h0A01_0203, 6'd8, 32'hC0A8_0001, 32'h2, 16'd5);
        offer(CMD_ADD, 32'h0A00_0000, 6'd8, 32'hC0A8_0002, 32'h3, 16'd5);
        offer(CMD_ADD, 32'h0A01_0000, 6'd16, 32'hC0A8_0003, 32'h2, 16'd9);
        // longest prefix wins; equal prefix and metric fall to the lower index
        offer(CMD_LOOKUP, 32'h0A01_0909, 6'd0, 32'h0, 32'h0, 16'h0);
        offer(CMD_LOOKUP, 32'h0AC8_0001, 6'd0, 32'h0, 32'h0, 16'h0);
        // same route again with unmasked host bits: refreshed in place, lower metric
        offer(CMD_ADD, 32'h0A09_0909, 6'd8, 32'hC0A8_0004, 32'h3, 16'd1);
        offer(CMD_LOOKUP, 32'h0AC8_0001, 6'd0, 32'h0, 32'h0, 16'h0);
        offer(CMD_LOOKUP, 32'hFFFF_FFFF, 6'd0, 32'h0, 32'h0, 16'h0);
        offer(CMD_LOOKUP, 32'h0B00_0000, 6'd0, 32'h0, 32'h0, 16'h0);
        // remove hit, the same remove again misses, rejected removes
        offer(CMD_REMOVE, 32'h0A00_0000, 6'd8, 32'h0, 32'h3, 16'h0);
        offer(CMD_REMOVE, 32'h0A00_0000, 6'd8, 32'h0, 32'h3, 16'h0);
        offer(CMD_REMOVE, 32'h0A00_0000, 6'd40, 32'h0, 32'h2, 16'h0);
        offer(CMD_REMOVE, 32'h0A00_0000, 6'd8, 32'h0, 32'h0, 16'h0);
        offer(CMD_LOOKUP, 32'h0AC8_0001, 6'd0, 32'h0, 32'h0, 16'h0);
        // drop the default route, then the lookup outside 10/8 misses
        offer(CMD_REMOVE, 32'h1234_5678, 6'd0, 32'h0, 32'hFFFF_FFFF, 16'h0);
        offer(CMD_LOOKUP, 32'h0B00_0000, 6'd0, 32'h0, 32'h0, 16'h0);

        // random part, one pacing scheme per phase
        run_phase(0, 0, 45, 15, 440);
        // add-heavy while the sender idles: the table fills and adds get refused
        run_phase(71, 0, 60, 10, 440);

        // long receiver hold-off while commands keep coming, then a full drain
        send_idle_pct = 0;
        stall_pct    <= 0;
        hold_token   <= hold_token + 1;
        repeat (8)
            random_command(40, 20);
        drain_results();

        // remove-heavy with a stalling receiver, then light idling on both sides
        run_phase(0, 71, 25, 35, 440);
        run_phase(13, 13, 35, 25, 440);

        drain_results();
        repeat (30) @(posedge aclk);

        $display("covered %0d commands: %0d add, %0d remove, %0d lookup, %0d unknown code",
                 beats_in, cmd_count[CMD_ADD], cmd_count[CMD_REMOVE],
                 cmd_count[CMD_LOOKUP], cmd_count[CMD_NONE]);
        $display("%0d lookups found a route, %0d adds met a full table, %0d failures",
                 lookup_hits, full_rejects, fail_count);
        if (fail_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
